/* design/permutation_unrank_macros.svh */
`ifndef PERMUTATION_UNRANK_MACROS_SVH
`define PERMUTATION_UNRANK_MACROS_SVH

// Check a property on every clock edge outside reset.
`define PU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define PU_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define PU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/pu_pkg.sv */
`default_nettype none

package pu_pkg;

    localparam int unsigned SIZE_W    = 4;
    localparam int unsigned RANK_W    = 19;
    localparam int unsigned DIGIT_W   = 4;
    localparam int unsigned MAX_N_DEF = 9;
    localparam int unsigned RECIP_SH  = 24;

    typedef logic [DIGIT_W-1:0] digit_t;

    typedef struct packed {
        logic [SIZE_W-1:0] n;
        logic              err;
        logic [RANK_W-1:0] r;
    } pu_stage_t;

    function automatic logic [RANK_W-1:0] fact_of(input logic [SIZE_W-1:0] m);
        logic [RANK_W-1:0] f;
        case (m)
            4'd0:    f = RANK_W'(1);
            4'd1:    f = RANK_W'(1);
            4'd2:    f = RANK_W'(2);
            4'd3:    f = RANK_W'(6);
            4'd4:    f = RANK_W'(24);
            4'd5:    f = RANK_W'(120);
            4'd6:    f = RANK_W'(720);
            4'd7:    f = RANK_W'(5040);
            4'd8:    f = RANK_W'(40320);
            4'd9:    f = RANK_W'(362880);
            default: f = '1;
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

/* design/pu_req_if.sv */
`default_nettype none

interface pu_req_if
    import pu_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [SIZE_W-1:0] set_size;
    logic [RANK_W-1:0] rank;

    modport source (output valid, output set_size, output rank, input ready);
    modport sink (input valid, input set_size, input rank, output ready);
endinterface

`default_nettype wire

/* design/pu_res_if.sv */
`default_nettype none

interface pu_res_if
    import pu_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [DIGIT_W-1:0] digit;
    logic               last;
    logic               error;

    modport source (output valid, output digit, output last, output error, input ready);
    modport sink (input valid, input digit, input last, input error, output ready);
endinterface

`default_nettype wire

/* design/permutation_unrank.sv */
`default_nettype none
`include "permutation_unrank_macros.svh"

// Unranks a request (set size n, one-based rank k) into the k-th lexicographic
// permutation of 1..n, delivered as n result items of one digit each, the last
// one flagged; a bad size or rank yields a single error item {0, last, error}.
// A request passes a MAX_N-stage pipeline, an input check followed by one stage
// per factorial-base digit, each dividing the rank by a constant, and then an
// output stage that turns one digit per cycle, while the result side is ready,
// into an unused value. The output stage sets the sustained rate: a request
// holds it for n result items (one for an error), up to MAX_N.
module permutation_unrank
    import pu_pkg::*;
#(
    parameter int unsigned MAX_N = MAX_N_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    pu_req_if.sink    req,
    pu_res_if.source  res
);

    localparam int unsigned PICK_W = (MAX_N > 1) ? $clog2(MAX_N) : 1;

    logic      vld_q [MAX_N];
    pu_stage_t st_q  [MAX_N];
    digit_t    dig_q [MAX_N][MAX_N];

    logic adv;
    logic load;
    logic emit;
    logic emit_last;

    logic              ser_valid_reg, ser_valid_next;
    logic              ser_err_reg, ser_err_next;
    logic [PICK_W-1:0] j_reg, j_next;
    logic [MAX_N-1:0]  used_reg, used_next;
    digit_t            ser_dig_reg [MAX_N];

    logic               res_valid_reg, res_valid_next;
    logic [DIGIT_W-1:0] res_digit_reg, res_digit_next;
    logic               res_last_reg, res_last_next;
    logic               res_error_reg, res_error_next;

    logic              found;
    logic [PICK_W-1:0] pick;
    digit_t            cnt;

    assign adv       = !vld_q[MAX_N-1] || load;
    assign req.ready = adv;

    for (genvar s = 0; s < MAX_N; s++) begin : g_stage
        logic      valid_reg, valid_next;
        pu_stage_t st_reg, st_next;
        digit_t    dig_reg  [MAX_N];
        digit_t    dig_next [MAX_N];

        if (s == 0) begin : g_check
            always_comb
            begin
                valid_next = req.valid;
                st_next.n  = req.set_size;
                st_next.err = (req.set_size == '0) || (req.set_size > SIZE_W'(MAX_N)) ||
                              (req.rank == '0) || (req.rank > fact_of(req.set_size));
                st_next.r  = req.rank - RANK_W'(1);
                for (int i = 0; i < MAX_N; i++)
                begin
                    dig_next[i] = '0;
                end
            end
        end else begin : g_div
            localparam logic [RANK_W-1:0]   DIV_R = RANK_W'(s + 1);
            localparam logic [RECIP_SH-1:0] RECIP = RECIP_SH'((64'd1 << RECIP_SH) / (s + 1));

            logic [RANK_W+RECIP_SH-1:0] prod;
            logic [RANK_W-1:0]          q0;
            logic [RANK_W-1:0]          rem0;

            always_comb
            begin
                prod = st_q[s-1].r * RECIP;
                q0   = prod[RANK_W+RECIP_SH-1:RECIP_SH];
                rem0 = st_q[s-1].r - RANK_W'(q0 * DIV_R);
                valid_next = vld_q[s-1];
                st_next    = st_q[s-1];
                for (int i = 0; i < MAX_N; i++)
                begin
                    dig_next[i] = dig_q[s-1][i];
                end
                if (rem0 >= DIV_R)
                begin
                    st_next.r   = q0 + RANK_W'(1);
                    dig_next[s] = DIGIT_W'(rem0 - DIV_R);
                end
                else
                begin
                    st_next.r   = q0;
                    dig_next[s] = DIGIT_W'(rem0);
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg <= 1'b0;
            end
            else if (adv)
            begin
                valid_reg <= valid_next;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                st_reg  <= st_next;
                dig_reg <= dig_next;
            end
        end

        assign vld_q[s] = valid_reg;
        assign st_q[s]  = st_reg;
        assign dig_q[s] = dig_reg;
    end

    // Pick the q-th value not yet used.
    always_comb
    begin
        cnt   = '0;
        found = 1'b0;
        pick  = '0;
        for (int v = 0; v < MAX_N; v++)
        begin
            if (!used_reg[v])
            begin
                if (!found && (cnt == ser_dig_reg[j_reg]))
                begin
                    found = 1'b1;
                    pick  = PICK_W'(v);
                end
                cnt = cnt + DIGIT_W'(1);
            end
        end
    end

    assign emit      = ser_valid_reg && (!res_valid_reg || res.ready);
    assign emit_last = ser_err_reg || (j_reg == '0);
    assign load      = vld_q[MAX_N-1] && (!ser_valid_reg || (emit && emit_last));

    always_comb
    begin
        ser_valid_next = ser_valid_reg;
        ser_err_next   = ser_err_reg;
        j_next         = j_reg;
        used_next      = used_reg;
        res_valid_next = res_valid_reg && !res.ready;
        res_digit_next = res_digit_reg;
        res_last_next  = res_last_reg;
        res_error_next = res_error_reg;
        if (emit)
        begin
            res_valid_next  = 1'b1;
            res_digit_next  = ser_err_reg ? '0 : DIGIT_W'(pick) + DIGIT_W'(1);
            res_last_next   = emit_last;
            res_error_next  = ser_err_reg;
            used_next[pick] = 1'b1;
            j_next          = j_reg - PICK_W'(1);
            if (emit_last)
            begin
                ser_valid_next = 1'b0;
            end
        end
        if (load)
        begin
            ser_valid_next = 1'b1;
            ser_err_next   = st_q[MAX_N-1].err;
            j_next         = PICK_W'(st_q[MAX_N-1].n - SIZE_W'(1));
            used_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_valid_reg <= 1'b0;
            ser_err_reg   <= 1'b0;
            j_reg         <= '0;
            used_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            ser_valid_reg <= ser_valid_next;
            ser_err_reg   <= ser_err_next;
            j_reg         <= j_next;
            used_reg      <= used_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ser_dig_reg <= dig_q[MAX_N-1];
        end
        res_digit_reg <= res_digit_next;
        res_last_reg  <= res_last_next;
        res_error_reg <= res_error_next;
    end

    assign res.valid = res_valid_reg;
    assign res.digit = res_digit_reg;
    assign res.last  = res_last_reg;
    assign res.error = res_error_reg;

    `PU_ASSERT_IMPL(a_pick_free, emit && !ser_err_reg, found && !used_reg[pick], "no free value for digit")
    `PU_ASSERT(a_digit_range, !ser_valid_reg || ser_err_reg || (ser_dig_reg[j_reg] <= DIGIT_W'(j_reg)), "digit exceeds position")
    `PU_ASSERT_NEXT(a_tail_hold, vld_q[MAX_N-1] && !load, vld_q[MAX_N-1], "stalled item dropped")

endmodule

`default_nettype wire

/* tb/permutation_unrank_check.sv */
`timescale 1ns / 100ps

module permutation_unrank_check
    import pu_pkg::*;
#(
    parameter int unsigned MAX_N = MAX_N_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    pu_req_if     req,
    pu_res_if     res,
    output int    mismatches,
    output int    digits_owed
);

    typedef struct packed {
        digit_t digit;
        logic   last;
        logic   error;
    } perm_item_t;

    perm_item_t expected_digits[$];

    function automatic int unsigned n_factorial(input int unsigned m);
        int unsigned f;
        f = 1;
        for (int unsigned i = 2; i <= m; i++)
            f *= i;
        return f;
    endfunction

    function automatic void predict_permutation(input logic [SIZE_W-1:0] n,
                                                input logic [RANK_W-1:0] k);
        int unsigned size;
        int unsigned left;
        int unsigned radix;
        int unsigned q;
        int unsigned seen;
        int unsigned pick;
        bit [15:0]   taken;
        perm_item_t  item;
        size = n;
        left = k;
        if (size == 0 || size > MAX_N || left == 0 || left > n_factorial(size))
        begin
            item.digit = '0;
            item.last  = 1'b1;
            item.error = 1'b1;
            expected_digits.push_back(item);
            return;
        end
        left  = left - 1;
        taken = '0;
        for (int unsigned pos = 0; pos < size; pos++)
        begin
            radix = n_factorial(size - 1 - pos);
            q     = left / radix;
            left  = left % radix;
            seen  = 0;
            pick  = 0;
            for (int unsigned v = 0; v < size; v++)
            begin
                if (!taken[v])
                begin
                    if (seen == q)
                    begin
                        pick = v;
                        break;
                    end
                    seen++;
                end
            end
            taken[pick] = 1'b1;
            item.digit  = DIGIT_W'(pick + 1);
            item.last   = (pos + 1 == size);
            item.error  = 1'b0;
            expected_digits.push_back(item);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        perm_item_t want;
        if (!rst_n)
        begin
            expected_digits.delete();
            mismatches  = 0;
            digits_owed = 0;
        end
        else
        begin
            if (req.valid && req.ready)
                predict_permutation(req.set_size, req.rank);
            if (res.valid && res.ready)
            begin
                if (expected_digits.size() == 0)
                begin
                    $error("unexpected item: digit %0d last %0b error %0b",
                           res.digit, res.last, res.error);
                    mismatches++;
                end
                else
                begin
                    want = expected_digits.pop_front();
                    if (res.digit !== want.digit)
                    begin
                        $error("digit: expected %0d, got %0d", want.digit, res.digit);
                        mismatches++;
                    end
                    if (res.last !== want.last)
                    begin
                        $error("last: expected %0b, got %0b", want.last, res.last);
                        mismatches++;
                    end
                    if (res.error !== want.error)
                    begin
                        $error("error: expected %0b, got %0b", want.error, res.error);
                        mismatches++;
                    end
                end
            end
            digits_owed = expected_digits.size();
        end
    end

endmodule

/* tb/permutation_unrank_test.sv */
`timescale 1ns / 100ps

module permutation_unrank_test;
    import pu_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   digits_owed;
    int   cycles;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   hold_left;

    pu_req_if req();
    pu_res_if res();

    permutation_unrank dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .res   (res)
    );

    permutation_unrank_check check
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .res         (res),
        .mismatches  (mismatches),
        .digits_owed (digits_owed)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("permutation_unrank_test NOT OK");
            $finish;
        end
    end

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                res.ready <= 1'b0;
                hold_left--;
            end
            else
                res.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic offer(input logic [SIZE_W-1:0] n, input logic [RANK_W-1:0] k);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid    <= 1'b1;
        req.set_size <= n;
        req.rank     <= k;
        do
            @(posedge clk);
        while (!req.ready);
        @(negedge clk);
    endtask

    task automatic offer_random();
        int unsigned pick;
        int unsigned n;
        int unsigned k;
        pick = $urandom_range(99);
        n    = $urandom_range(9, 1);
        if (pick < 80)
            k = $urandom_range(check.n_factorial(n), 1);
        else if (pick < 88)
            k = $urandom_range(2 ** RANK_W - 1, check.n_factorial(n) + 1);
        else if (pick < 92)
            k = 0;
        else
        begin
            n = $urandom_range(2 ** SIZE_W - 1, 0);
            k = $urandom();
        end
        offer(SIZE_W'(n), RANK_W'(k));
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        wait (digits_owed == 0);
        @(negedge clk);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
            offer_random();
        drain();
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        cycles         = 0;
        hold_left      = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        req.valid      = 1'b0;
        req.set_size   = '0;
        req.rank       = '0;
        res.ready      = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        offer(0, 0);
        offer(0, 1);
        offer(1, 1);
        offer(1, 0);
        offer(1, 2);
        offer(2, 1);
        offer(2, 2);
        offer(2, 3);
        offer(3, 1);
        offer(3, 4);
        offer(3, 6);
        offer(3, 7);
        offer(4, 24);
        offer(5, 60);
        offer(8, 40320);
        offer(8, 40321);
        offer(9, 1);
        offer(9, 181440);
        offer(9, 362880);
        offer(9, 362881);
        offer(9, 2 ** RANK_W - 1);
        offer(10, 1);
        offer(2 ** SIZE_W - 1, 1);
        offer(2 ** SIZE_W - 1, 2 ** RANK_W - 1);
        offer(7, 0);
        drain();

        req.valid <= 1'b0;
        @(posedge clk);
        hold_left = 300;
        @(negedge clk);
        run_phase(0, 0, 30);

        run_phase(0, 0, 85);
        run_phase(82, 0, 85);
        run_phase(0, 82, 85);
        run_phase(33, 33, 85);

        repeat (20) @(posedge clk);
        if (mismatches == 0 && digits_owed == 0)
            $display("permutation_unrank_test OK");
        else
            $display("permutation_unrank_test NOT OK");
        $finish;
    end

endmodule
